// ===== rtl/core/rrd_pkg.sv =====
`default_nettype none

package rrd_pkg;

	// List geometry
	localparam int MAX_CHANNELS = 16;
	localparam int IDX_W        = $clog2(MAX_CHANNELS);
	localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);
	localparam int ID_W         = 4;
	localparam int MASK_W       = 1 << ID_W;
	localparam int CMD_W        = 2;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ATTACH  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

	// Access to the channel list: one write port, one read port
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [ID_W-1:0]  wdata;
		logic [IDX_W-1:0] raddr;
	} list_ctl_t;

	// Result of one item
	typedef struct packed {
		logic            accepted;
		logic [ID_W-1:0] target_channel;
		logic            broadcast;
		logic            list_empty;
		logic            error;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/rrd_if.sv =====
`default_nettype none

// Request channel
interface rrd_req_if;
	logic                          valid;
	logic                          ready;
	logic [rrd_pkg::CMD_W-1:0]     cmd;
	logic [rrd_pkg::ID_W-1:0]      channel_id;
	logic                          is_delimiter;
	logic [rrd_pkg::MASK_W-1:0]    ready_mask;

	modport source (output valid, output cmd, output channel_id, output is_delimiter,
		output ready_mask, input ready);
	modport sink (input valid, input cmd, input channel_id, input is_delimiter,
		input ready_mask, output ready);
endinterface

// Response channel
interface rrd_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      accepted;
	logic [rrd_pkg::ID_W-1:0]  target_channel;
	logic                      broadcast;
	logic                      list_empty;
	logic                      error;

	modport source (output valid, output accepted, output target_channel, output broadcast,
		output list_empty, output error, input ready);
	modport sink (input valid, input accepted, input target_channel, input broadcast,
		input list_empty, input error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rrd_list.sv =====
`default_nettype none

module rrd_list (
	input  wire logic                     clk,
	input  wire rrd_pkg::list_ctl_t       ctl,
	output logic [rrd_pkg::ID_W-1:0]      rdata
);

	logic [rrd_pkg::ID_W-1:0] list_q [rrd_pkg::MAX_CHANNELS];

	// Write one entry per cycle; contents are undefined until written
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			list_q[ctl.waddr] <= ctl.wdata;
		end
	end

	// Single registered read port: data appears in the cycle after its address
	always_ff @(posedge clk) begin
		rdata <= list_q[ctl.raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/rrd_seq.sv =====
`default_nettype none

module rrd_seq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rrd_req_if.sink            req,
	output rrd_pkg::list_ctl_t ctl,
	input  wire logic [rrd_pkg::ID_W-1:0] rdata,
	output logic               res_valid,
	input  wire logic          res_take,
	output rrd_pkg::rsp_t      res
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FIND  = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	localparam int IDX_W = rrd_pkg::IDX_W;
	localparam int CNT_W = rrd_pkg::CNT_W;

	logic [2:0]                   state_q;
	logic [IDX_W-1:0]             idx_q;
	logic [IDX_W-1:0]             wr_q;
	logic [CNT_W-1:0]             it_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [IDX_W-1:0]             rr_q;
	logic [rrd_pkg::ID_W-1:0]     id_q;
	logic [rrd_pkg::MASK_W-1:0]   ready_q;
	logic                         acc_q;
	logic [rrd_pkg::ID_W-1:0]     tgt_q;
	logic                         bc_q;
	logic                         err_q;

	logic                         take_in;
	logic                         attach_ok;
	logic [CNT_W-1:0]             idx_inc;
	logic                         idx_last;
	logic [IDX_W-1:0]             idx_wrap;
	logic [CNT_W-1:0]             cnt_dec;
	logic                         match;
	logic                         drop_now;

	// Shared index unit: increment, compare against count, wrap
	assign idx_inc  = {1'b0, idx_q} + 1'b1;
	assign idx_last = (idx_inc == cnt_q);
	assign idx_wrap = idx_last ? '0 : idx_inc[IDX_W-1:0];
	assign cnt_dec  = cnt_q - 1'b1;

	// Drop the entry once the last later entry has moved down
	assign match    = (rdata == id_q);
	assign drop_now = idx_last && ((state_q == ST_FIND && match) || state_q == ST_SHIFT);

	assign req.ready = (state_q == ST_IDLE);
	assign take_in   = req.valid && req.ready;
	assign attach_ok = (cnt_q < CNT_W'(rrd_pkg::MAX_CHANNELS));

	// Steer the list ports: the read address is always that of the entry examined in the next cycle
	always_comb begin
		ctl.we    = 1'b0;
		ctl.waddr = wr_q;
		ctl.wdata = rdata;
		ctl.raddr = idx_inc[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				// Prefetch the first entry to examine; append on attach
				ctl.raddr = (req.cmd == rrd_pkg::CMD_WRITE) ? rr_q : '0;
				if (take_in && req.cmd == rrd_pkg::CMD_ATTACH && attach_ok) begin
					ctl.we    = 1'b1;
					ctl.waddr = cnt_q[IDX_W-1:0];
					ctl.wdata = req.channel_id;
				end
			end
			ST_SCAN: begin
				ctl.raddr = idx_wrap;
			end
			ST_SHIFT: begin
				// Move the entry just read down one place
				ctl.we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rr_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take_in) begin
						case (req.cmd)
							rrd_pkg::CMD_WRITE: begin
								if (req.is_delimiter || cnt_q == '0) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							rrd_pkg::CMD_ATTACH: begin
								if (attach_ok) begin
									cnt_q <= cnt_q + 1'b1;
								end
								state_q <= ST_FIN;
							end
							rrd_pkg::CMD_RELEASE: begin
								state_q <= (cnt_q == '0) ? ST_FIN : ST_FIND;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (ready_q[rdata]) begin
						rr_q    <= idx_wrap;
						state_q <= ST_FIN;
					end else if (it_q + 1'b1 == cnt_q) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIND, ST_SHIFT: begin
					if (drop_now) begin
						cnt_q <= cnt_dec;
						if ({1'b0, rr_q} >= cnt_dec) begin
							rr_q <= '0;
						end
						state_q <= ST_FIN;
					end else if (state_q == ST_FIND) begin
						if (match) begin
							state_q <= ST_SHIFT;
						end else if (idx_last) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take_in) begin
					id_q    <= req.channel_id;
					ready_q <= req.ready_mask;
					it_q    <= '0;
					acc_q   <= 1'b0;
					tgt_q   <= '0;
					bc_q    <= 1'b0;
					err_q   <= 1'b0;
					idx_q   <= (req.cmd == rrd_pkg::CMD_WRITE) ? rr_q : '0;
					case (req.cmd)
						rrd_pkg::CMD_WRITE: begin
							if (req.is_delimiter) begin
								acc_q <= 1'b1;
								bc_q  <= 1'b1;
							end
						end
						rrd_pkg::CMD_ATTACH: begin
							acc_q <= attach_ok;
							err_q <= !attach_ok;
						end
						rrd_pkg::CMD_RELEASE: begin
							err_q <= (cnt_q == '0);
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (ready_q[rdata]) begin
					acc_q <= 1'b1;
					tgt_q <= rdata;
				end else begin
					idx_q <= idx_wrap;
					it_q  <= it_q + 1'b1;
				end
			end
			ST_FIND: begin
				if (!match) begin
					if (idx_last) begin
						err_q <= 1'b1;
					end else begin
						idx_q <= idx_inc[IDX_W-1:0];
					end
				end else if (idx_last) begin
					acc_q <= 1'b1;
				end else begin
					// Hold the hole, advance the read to the next entry
					wr_q  <= idx_q;
					idx_q <= idx_inc[IDX_W-1:0];
				end
			end
			ST_SHIFT: begin
				if (idx_last) begin
					acc_q <= 1'b1;
				end else begin
					wr_q  <= idx_q;
					idx_q <= idx_inc[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign res_valid          = (state_q == ST_FIN);
	assign res.accepted       = acc_q;
	assign res.target_channel = tgt_q;
	assign res.broadcast      = bc_q;
	assign res.list_empty     = (cnt_q == '0);
	assign res.error          = err_q;

	// Count never exceeds the list depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(rrd_pkg::MAX_CHANNELS))
		else $error("channel count beyond list depth");

	// Position stays inside the list, or at zero when it is empty
	a_rr_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rr_q} < cnt_q) || (rr_q == '0))
		else $error("round-robin position outside list");

	// Scans only run over a non-empty list
	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_FIND || state_q == ST_SHIFT) |-> (cnt_q != '0))
		else $error("list scan with empty list");

	// A refused message leaves the position untouched
	a_refuse_keeps_rr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !ready_q[rdata] && it_q + 1'b1 == cnt_q) |=> $stable(rr_q))
		else $error("position moved on refused message");

	// A result is never both accepted and in error
	a_acc_err: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.accepted && res.error))
		else $error("result both accepted and in error");

endmodule

`default_nettype wire

// ===== rtl/core/round_robin_ready_dispatcher_core.sv =====
// Channel | Dir | Beat contents                                    | Handshake
// req     | in  | cmd, channel_id, is_delimiter, ready_mask        | valid/ready
// rsp     | out | accepted, target_channel, broadcast, list_empty, | valid/ready
//         |     | error                                            |
//
// One beat in gives exactly one beat out; one item is worked on at a time.
// Delimiter, attach, unused commands and writes or releases on an empty list go straight to the result.
// Dispatch reads one list entry a cycle and tries at most count entries.
// Release searches, then shifts later entries down one a cycle.
// Reset empties the list and clears the position; no clearing pass is needed.
// A waiting response sits in the output register while the next beat is taken.
`default_nettype none

module round_robin_ready_dispatcher_core (
	input  wire logic clk,
	input  wire logic arst_n,
	rrd_req_if.sink   req,
	rrd_rsp_if.source rsp
);

	rrd_pkg::list_ctl_t       ctl;
	logic [rrd_pkg::ID_W-1:0] rdata;
	logic                     res_valid;
	logic                     res_take;
	rrd_pkg::rsp_t            res;
	logic                     out_valid_q;
	rrd_pkg::rsp_t            out_q;

	rrd_list u_list (
		.clk   (clk),
		.ctl   (ctl),
		.rdata (rdata)
	);

	rrd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	// Load the output register when it is empty or being drained
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.accepted       = out_q.accepted;
	assign rsp.target_channel = out_q.target_channel;
	assign rsp.broadcast      = out_q.broadcast;
	assign rsp.list_empty     = out_q.list_empty;
	assign rsp.error          = out_q.error;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb;

	localparam int CMD_W  = rrd_pkg::CMD_W;
	localparam int ID_W   = rrd_pkg::ID_W;
	localparam int MASK_W = rrd_pkg::MASK_W;

	// Command code with no meaning in the block
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Traffic mixes for the random part
	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic clk = 1'b0;
	logic arst_n;

	rrd_req_if req_ch ();
	rrd_rsp_if rsp_ch ();

	round_robin_ready_dispatcher_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// Shadow of the channel list and round-robin position
	logic [ID_W-1:0] route_list [rrd_pkg::MAX_CHANNELS];
	int unsigned     route_count;
	int unsigned     route_pos;

	rrd_pkg::rsp_t pending_rsp [$];
	int   mismatch_count;
	int   rsp_beats;
	bit   req_quiet;
	bit   rsp_quiet;
	int   hold_left;

	// Work out the response to one accepted beat and advance the shadow state
	function automatic rrd_pkg::rsp_t route_item(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
		logic delim, logic [MASK_W-1:0] mask);
		rrd_pkg::rsp_t r;
		int unsigned   pos;
		int unsigned   found;
		int unsigned   i;
		bit            hit;
		r   = '0;
		hit = 1'b0;
		case (cmd)
			rrd_pkg::CMD_WRITE: begin
				if (delim) begin
					r.accepted  = 1'b1;
					r.broadcast = 1'b1;
				end else if (route_count > 0) begin
					pos = route_pos;
					for (i = 0; i < route_count; i++) begin
						if (!hit && mask[route_list[pos]]) begin
							hit              = 1'b1;
							r.accepted       = 1'b1;
							r.target_channel = route_list[pos];
							route_pos        = (pos + 1) % route_count;
						end
						pos = (pos + 1) % route_count;
					end
				end
			end
			rrd_pkg::CMD_ATTACH: begin
				if (route_count >= rrd_pkg::MAX_CHANNELS) begin
					r.error = 1'b1;
				end else begin
					route_list[route_count] = id;
					route_count++;
					r.accepted = 1'b1;
				end
			end
			rrd_pkg::CMD_RELEASE: begin
				found = route_count;
				for (i = 0; i < route_count; i++) begin
					if (found == route_count && route_list[i] == id)
						found = i;
				end
				if (found >= route_count) begin
					r.error = 1'b1;
				end else begin
					for (i = found; i + 1 < route_count; i++)
						route_list[i] = route_list[i + 1];
					route_count--;
					if (route_pos >= route_count)
						route_pos = 0;
					r.accepted = 1'b1;
				end
			end
			default: ;
		endcase
		r.list_empty = (route_count == 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: response beat %0d: %s got %0d, want %0d",
			$time, rsp_beats, what, got, want);
		mismatch_count++;
	endtask

	// Offer one beat, with the odd idle cycle first, and hold it until taken
	task automatic send_beat(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, logic delim,
		logic [MASK_W-1:0] mask);
		rrd_pkg::rsp_t predicted;
		@(negedge clk);
		while (!req_quiet && $urandom_range(0, 99) < 7) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.cmd          <= cmd;
		req_ch.channel_id   <= id;
		req_ch.is_delimiter <= delim;
		req_ch.ready_mask   <= mask;
		do @(posedge clk); while (!req_ch.ready);
		predicted = route_item(cmd, id, delim, mask);
		pending_rsp.insert(pending_rsp.size(), predicted);
	endtask

	// Build one random beat; a release mostly names an attached id
	task automatic send_random(mix_t mix);
		int unsigned      pick;
		int unsigned      attach_pct;
		int unsigned      release_pct;
		logic [ID_W-1:0]  id;
		logic [MASK_W-1:0] mask;
		logic [CMD_W-1:0] cmd;
		case (mix)
			MIX_FILL:  begin attach_pct = 50; release_pct = 10; end
			MIX_DRAIN: begin attach_pct = 10; release_pct = 50; end
			default:   begin attach_pct = 25; release_pct = 25; end
		endcase
		pick = $urandom_range(0, 99);
		id   = ID_W'($urandom);
		mask = MASK_W'($urandom);
		if (pick < 3)
			cmd = CMD_UNUSED;
		else if (pick < 3 + attach_pct)
			cmd = rrd_pkg::CMD_ATTACH;
		else if (pick < 3 + attach_pct + release_pct)
			cmd = rrd_pkg::CMD_RELEASE;
		else
			cmd = rrd_pkg::CMD_WRITE;
		if (cmd == rrd_pkg::CMD_RELEASE && route_count > 0 && $urandom_range(0, 99) < 80)
			id = route_list[$urandom_range(0, route_count - 1)];
		if (cmd == rrd_pkg::CMD_WRITE) begin
			case ($urandom_range(0, 5))
				0: mask = '1;
				1: mask = '0;
				2: mask = (route_count > 0) ?
					MASK_W'(1) << route_list[$urandom_range(0, route_count - 1)] : '0;
				3: mask = MASK_W'($urandom & $urandom);
				default: ;
			endcase
		end
		send_beat(cmd, id, $urandom_range(0, 99) < 15, mask);
	endtask

	// Edge cases: empty list, duplicates, wrap-around, absent ids, unused command
	task automatic test_directed();
		send_beat(rrd_pkg::CMD_WRITE, 4'd3, 1'b0, 16'hFFFF);
		send_beat(rrd_pkg::CMD_WRITE, 4'd0, 1'b1, 16'h0000);
		send_beat(CMD_UNUSED, 4'd15, 1'b1, 16'hFFFF);
		send_beat(rrd_pkg::CMD_RELEASE, 4'd5, 1'b0, 16'h0000);
		send_beat(rrd_pkg::CMD_ATTACH, 4'd0, 1'b1, 16'hFFFF);
		send_beat(rrd_pkg::CMD_ATTACH, 4'd15, 1'b0, 16'h0000);
		send_beat(rrd_pkg::CMD_ATTACH, 4'd15, 1'b1, 16'h5A5A);
		send_beat(rrd_pkg::CMD_ATTACH, 4'd7, 1'b0, 16'hA5A5);
		send_beat(rrd_pkg::CMD_WRITE, 4'd15, 1'b0, 16'hFFFF);
		send_beat(rrd_pkg::CMD_WRITE, 4'd0, 1'b0, 16'h0000);
		send_beat(rrd_pkg::CMD_WRITE, 4'd9, 1'b0, 16'h0080);
		send_beat(rrd_pkg::CMD_WRITE, 4'd0, 1'b0, 16'h8000);
		send_beat(rrd_pkg::CMD_WRITE, ID_W'($urandom), 1'b1, MASK_W'($urandom));
		send_beat(CMD_UNUSED, ID_W'($urandom), 1'b0, MASK_W'($urandom));
		send_beat(rrd_pkg::CMD_RELEASE, 4'd15, 1'b1, 16'hFFFF);
		send_beat(rrd_pkg::CMD_RELEASE, 4'd9, 1'b0, 16'h0000);
		send_beat(rrd_pkg::CMD_RELEASE, 4'd7, 1'b0, 16'hFFFF);
		send_beat(rrd_pkg::CMD_WRITE, 4'd15, 1'b0, 16'h8001);
		send_beat(rrd_pkg::CMD_RELEASE, 4'd0, 1'b0, 16'h0000);
		send_beat(rrd_pkg::CMD_RELEASE, 4'd15, 1'b0, 16'h0000);
		send_beat(rrd_pkg::CMD_WRITE, 4'd0, 1'b0, 16'h7FFE);
	endtask

	// Random traffic, swinging between filling and draining the list
	task automatic test_random(int n);
		mix_t mix;
		mix = MIX_EVEN;
		for (int k = 0; k < n; k++) begin
			if (k % 64 == 0)
				mix = mix_t'($urandom_range(0, 2));
			send_random(mix);
		end
	endtask

	// Back-to-back beats with neither side idling
	task automatic test_streaming(int n);
		req_quiet = 1'b1;
		rsp_quiet = 1'b1;
		for (int k = 0; k < n; k++)
			send_random(k < n / 2 ? MIX_FILL : MIX_EVEN);
		req_quiet = 1'b0;
		rsp_quiet = 1'b0;
	endtask

	// Hold the response side off for a long stretch while beats keep coming
	task automatic test_backpressure(int n);
		hold_left = 300;
		for (int k = 0; k < n; k++)
			send_random(MIX_EVEN);
	endtask

	// Response ready: long hold-off first, then random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else begin
			rsp_ch.ready <= rsp_quiet || $urandom_range(0, 99) >= 7;
		end
	end

	// Check each response beat against the oldest prediction
	always @(posedge clk) begin
		rrd_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("beat with nothing pending", 1, 0);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.accepted !== want.accepted)
					report_mismatch("accepted", int'(rsp_ch.accepted),
						int'(want.accepted));
				if (rsp_ch.target_channel !== want.target_channel)
					report_mismatch("target_channel", int'(rsp_ch.target_channel),
						int'(want.target_channel));
				if (rsp_ch.broadcast !== want.broadcast)
					report_mismatch("broadcast", int'(rsp_ch.broadcast),
						int'(want.broadcast));
				if (rsp_ch.list_empty !== want.list_empty)
					report_mismatch("list_empty", int'(rsp_ch.list_empty),
						int'(want.list_empty));
				if (rsp_ch.error !== want.error)
					report_mismatch("error", int'(rsp_ch.error), int'(want.error));
			end
			rsp_beats++;
		end
	end

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.cmd          = rrd_pkg::CMD_WRITE;
		req_ch.channel_id   = '0;
		req_ch.is_delimiter = 1'b0;
		req_ch.ready_mask   = '0;
		rsp_ch.ready        = 1'b0;
		route_count         = 0;
		route_pos           = 0;
		mismatch_count      = 0;
		rsp_beats           = 0;
		req_quiet           = 1'b0;
		rsp_quiet           = 1'b0;
		hold_left           = 0;
		for (int k = 0; k < rrd_pkg::MAX_CHANNELS; k++)
			route_list[k] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(1000);
		test_streaming(300);
		test_backpressure(100);
		test_random(600);

		// Drop valid, drain, then allow for the longest dispatch
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("[round_robin_ready_dispatcher_core] OK");
		else
			$display("[round_robin_ready_dispatcher_core] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#(5_000_000);
		$display("[round_robin_ready_dispatcher_core] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
